// File: design/direct_mapped_data_tlb_top_macros.svh
// Assertion macros used by the back end of the translation buffer.
`ifndef DIRECT_MAPPED_DATA_TLB_TOP_MACROS_SVH
`define DIRECT_MAPPED_DATA_TLB_TOP_MACROS_SVH

// Condition that must hold at every clock edge outside reset.
`define DMDTLB_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Consequence that must hold in the cycle after the antecedent.
`define DMDTLB_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: design/dmdtlb_pkg.sv
// Package with the shared types and constants of the data translation buffer.
`timescale 1ns / 1ps
package dmdtlb_pkg;

    localparam int VADDR_W     = 64;
    localparam int PTE_W       = 64;
    localparam int VA_LIMIT_W  = 49;
    localparam int PAGE_SHIFT  = 12;
    localparam int PAGE_BITS   = VA_LIMIT_W - PAGE_SHIFT;
    localparam int WALK_PAGE_W = 35;
    localparam int PERM_W      = 3;
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    localparam logic [VA_LIMIT_W-1:0] VA_LIMIT_RESET = 49'h0_8000_0000_0000;

    localparam logic [1:0] OP_LOOKUP = 2'd0;
    localparam logic [1:0] OP_FILL   = 2'd1;
    localparam logic [1:0] OP_FLUSH  = 2'd2;

    localparam logic [1:0] ACC_READ  = 2'd0;
    localparam logic [1:0] ACC_STORE = 2'd1;
    localparam logic [1:0] ACC_FETCH = 2'd2;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_MISS  = 2'd1;
    localparam logic [1:0] ST_TRANS = 2'd2;
    localparam logic [1:0] ST_PERM  = 2'd3;

    localparam logic [PERM_W-1:0] NEED_R = 3'b001;
    localparam logic [PERM_W-1:0] NEED_W = 3'b010;
    localparam logic [PERM_W-1:0] NEED_X = 3'b100;

    typedef enum logic [1:0] {
        CMD_LOOKUP,
        CMD_FILL,
        CMD_FLUSH,
        CMD_REPLY
    } cmd_kind_t;

    typedef enum logic [1:0] {
        B_IDLE,
        B_LOOKUP,
        B_SWEEP
    } back_state_t;

    typedef struct packed {
        cmd_kind_t              kind;
        logic [1:0]             status;
        logic [PERM_W-1:0]      need;
        logic [PAGE_BITS-1:0]   page;
        logic [PAGE_SHIFT-1:0]  offset;
        logic [PTE_W-1:0]       pte;
    } cmd_t;

    typedef struct packed {
        logic [1:0]             status;
        logic [VADDR_W-1:0]     host_addr;
        logic [WALK_PAGE_W-1:0] walk_page;
    } res_t;

    typedef struct packed {
        logic init_busy;
    } back_status_t;

endpackage

// File: design/dmdtlb_req_if.sv
// Request channel interface: one transaction per lookup, fill or flush.
`timescale 1ns / 1ps
interface dmdtlb_req_if;
    logic                             valid;
    logic                             ready;
    logic [1:0]                       opcode;
    logic [dmdtlb_pkg::VADDR_W-1:0]   vaddr;
    logic [1:0]                       access_kind;
    logic [dmdtlb_pkg::PTE_W-1:0]     walked_entry;

    modport source (output valid, opcode, vaddr, access_kind, walked_entry, input ready);
    modport sink   (input valid, opcode, vaddr, access_kind, walked_entry, output ready);
endinterface

// File: design/dmdtlb_rsp_if.sv
// Response channel interface: one transaction per accepted request.
`timescale 1ns / 1ps
interface dmdtlb_rsp_if;
    logic                                 valid;
    logic                                 ready;
    logic [1:0]                           status;
    logic [dmdtlb_pkg::VADDR_W-1:0]       host_addr;
    logic [dmdtlb_pkg::WALK_PAGE_W-1:0]   walk_page;

    modport source (output valid, status, host_addr, walk_page, input ready);
    modport sink   (input valid, status, host_addr, walk_page, output ready);
endinterface

// File: design/dmdtlb_ram.sv
// Generic single-port RAM with registered read data.
`timescale 1ns / 1ps
module dmdtlb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[addr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: design/dmdtlb_front.sv
// Front end: takes request transactions, holds the address limit and classifies each request.
`timescale 1ns / 1ps
module dmdtlb_front (
    input  logic                                 clk,
    input  logic                                 rst_n,
    dmdtlb_req_if.sink                           req,
    input  logic                                 cfg_wr_en,
    input  logic [dmdtlb_pkg::VA_LIMIT_W-1:0]    cfg_wr_data,
    input  logic                                 q_full,
    input  dmdtlb_pkg::back_status_t             back_status,
    output logic                                 q_push,
    output dmdtlb_pkg::cmd_t                     q_cmd
);

    logic [dmdtlb_pkg::VA_LIMIT_W-1:0] va_limit_reg;
    logic [dmdtlb_pkg::VADDR_W-1:0]    va_s;
    logic [dmdtlb_pkg::PERM_W-1:0]     need;
    logic                              out_of_range;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_limit_reg <= dmdtlb_pkg::VA_LIMIT_RESET;
        end
        else if (cfg_wr_en)
        begin
            va_limit_reg <= cfg_wr_data;
        end
    end

    assign req.ready = !q_full && !back_status.init_busy;
    assign q_push    = req.valid && req.ready;

    always_comb
    begin
        case (req.access_kind)
            dmdtlb_pkg::ACC_STORE: need = dmdtlb_pkg::NEED_W;
            dmdtlb_pkg::ACC_FETCH: need = dmdtlb_pkg::NEED_X;
            default:               need = dmdtlb_pkg::NEED_R;
        endcase

        // The top byte carries a pointer tag except on instruction fetches.
        if (req.access_kind == dmdtlb_pkg::ACC_FETCH)
        begin
            va_s = req.vaddr;
        end
        else
        begin
            va_s = {8'h00, req.vaddr[55:0]};
        end

        out_of_range = (va_s[dmdtlb_pkg::VADDR_W-1:dmdtlb_pkg::VA_LIMIT_W] != '0)
                    || (va_s[dmdtlb_pkg::VA_LIMIT_W-1:0] >= va_limit_reg);

        q_cmd.status = dmdtlb_pkg::ST_OK;
        q_cmd.need   = need;
        q_cmd.page   = va_s[dmdtlb_pkg::VA_LIMIT_W-1:dmdtlb_pkg::PAGE_SHIFT];
        q_cmd.offset = va_s[dmdtlb_pkg::PAGE_SHIFT-1:0];
        q_cmd.pte    = req.walked_entry;

        case (req.opcode)
            dmdtlb_pkg::OP_FLUSH:
            begin
                q_cmd.kind = dmdtlb_pkg::CMD_FLUSH;
            end
            dmdtlb_pkg::OP_LOOKUP:
            begin
                if (out_of_range)
                begin
                    q_cmd.kind   = dmdtlb_pkg::CMD_REPLY;
                    q_cmd.status = dmdtlb_pkg::ST_TRANS;
                end
                else
                begin
                    q_cmd.kind = dmdtlb_pkg::CMD_LOOKUP;
                end
            end
            dmdtlb_pkg::OP_FILL:
            begin
                // An unmapped entry faults and is never cached.
                if (out_of_range || req.walked_entry == '0)
                begin
                    q_cmd.kind   = dmdtlb_pkg::CMD_REPLY;
                    q_cmd.status = dmdtlb_pkg::ST_TRANS;
                end
                else
                begin
                    q_cmd.kind = dmdtlb_pkg::CMD_FILL;
                end
            end
            default:
            begin
                q_cmd.kind = dmdtlb_pkg::CMD_REPLY;
            end
        endcase
    end

endmodule

// File: design/dmdtlb_queue.sv
// Short command queue between the front end and the back end.
`timescale 1ns / 1ps
module dmdtlb_queue (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  dmdtlb_pkg::cmd_t     push_cmd,
    input  logic                 pop,
    output logic                 full,
    output logic                 not_empty,
    output dmdtlb_pkg::cmd_t     head
);

    dmdtlb_pkg::cmd_t                     entries_reg [dmdtlb_pkg::QUEUE_DEPTH];
    logic [dmdtlb_pkg::QUEUE_PTR_W-1:0]   wr_ptr_reg;
    logic [dmdtlb_pkg::QUEUE_PTR_W-1:0]   rd_ptr_reg;
    logic [dmdtlb_pkg::QUEUE_CNT_W-1:0]   count_reg;
    logic [dmdtlb_pkg::QUEUE_CNT_W-1:0]   count_next;

    assign full      = (count_reg == dmdtlb_pkg::QUEUE_CNT_W'(dmdtlb_pkg::QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign head      = entries_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + dmdtlb_pkg::QUEUE_CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - dmdtlb_pkg::QUEUE_CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + dmdtlb_pkg::QUEUE_PTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + dmdtlb_pkg::QUEUE_PTR_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

// File: design/dmdtlb_back.sv
// Back end: entry memory, tag compare, permission check, fills, flush sweep and result register.
`timescale 1ns / 1ps
`include "direct_mapped_data_tlb_top_macros.svh"
module dmdtlb_back #(
    parameter int TLB_INDEX_BITS = 10
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         q_not_empty,
    input  dmdtlb_pkg::cmd_t             q_head,
    output logic                         q_pop,
    output dmdtlb_pkg::back_status_t     back_status,
    dmdtlb_rsp_if.source                 rsp
);

    localparam int TAG_W = dmdtlb_pkg::PAGE_BITS - TLB_INDEX_BITS;
    localparam int RAM_W = 1 + TAG_W + dmdtlb_pkg::PTE_W;
    localparam int DEPTH = 1 << TLB_INDEX_BITS;

    dmdtlb_pkg::back_state_t       state_reg, state_next;
    logic [TLB_INDEX_BITS-1:0]     sweep_cnt_reg, sweep_cnt_next;
    logic                          init_busy_reg, init_busy_next;
    dmdtlb_pkg::cmd_t              cur_reg, cur_next;
    logic                          rsp_valid_reg, rsp_valid_next;
    dmdtlb_pkg::res_t              rsp_res_reg, rsp_res_next;

    logic                          ram_we;
    logic                          ram_re;
    logic [TLB_INDEX_BITS-1:0]     ram_addr;
    logic [RAM_W-1:0]              ram_wdata;
    logic [RAM_W-1:0]              ram_rdata;

    logic                          out_free;
    logic                          rd_valid;
    logic [TAG_W-1:0]              rd_tag;
    logic [dmdtlb_pkg::PTE_W-1:0]  rd_pte;

    function automatic dmdtlb_pkg::res_t finish(
        input logic [dmdtlb_pkg::PTE_W-1:0]      pte,
        input logic [dmdtlb_pkg::PERM_W-1:0]     need,
        input logic [dmdtlb_pkg::PAGE_SHIFT-1:0] offset
    );
        dmdtlb_pkg::res_t r;
        r = '0;
        if ((pte[dmdtlb_pkg::PERM_W-1:0] & need) != need)
        begin
            r.status = dmdtlb_pkg::ST_PERM;
        end
        else
        begin
            r.status    = dmdtlb_pkg::ST_OK;
            r.host_addr = {pte[dmdtlb_pkg::PTE_W-1:dmdtlb_pkg::PERM_W],
                           {dmdtlb_pkg::PERM_W{1'b0}}}
                        + {{(dmdtlb_pkg::VADDR_W - dmdtlb_pkg::PAGE_SHIFT){1'b0}}, offset};
        end
        return r;
    endfunction

    dmdtlb_ram #(
        .WIDTH (RAM_W),
        .DEPTH (DEPTH)
    ) u_entries (
        .clk   (clk),
        .we    (ram_we),
        .re    (ram_re),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    assign rd_valid = ram_rdata[RAM_W-1];
    assign rd_tag   = ram_rdata[TAG_W+dmdtlb_pkg::PTE_W-1:dmdtlb_pkg::PTE_W];
    assign rd_pte   = ram_rdata[dmdtlb_pkg::PTE_W-1:0];

    assign out_free              = !rsp_valid_reg || rsp.ready;
    assign back_status.init_busy = init_busy_reg;

    assign rsp.valid     = rsp_valid_reg;
    assign rsp.status    = rsp_res_reg.status;
    assign rsp.host_addr = rsp_res_reg.host_addr;
    assign rsp.walk_page = rsp_res_reg.walk_page;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= dmdtlb_pkg::B_SWEEP;
            sweep_cnt_reg <= '0;
            init_busy_reg <= 1'b1;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            sweep_cnt_reg <= sweep_cnt_next;
            init_busy_reg <= init_busy_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg     <= cur_next;
        rsp_res_reg <= rsp_res_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        sweep_cnt_next = sweep_cnt_reg;
        init_busy_next = init_busy_reg;
        cur_next       = cur_reg;
        rsp_res_next   = rsp_res_reg;
        rsp_valid_next = rsp_valid_reg && !rsp.ready;
        q_pop          = 1'b0;
        ram_we         = 1'b0;
        ram_re         = 1'b0;
        ram_addr       = q_head.page[TLB_INDEX_BITS-1:0];
        ram_wdata      = {1'b1, q_head.page[dmdtlb_pkg::PAGE_BITS-1:TLB_INDEX_BITS],
                          q_head.pte};

        case (state_reg)
            dmdtlb_pkg::B_IDLE:
            begin
                if (q_not_empty && out_free)
                begin
                    q_pop = 1'b1;
                    case (q_head.kind)
                        dmdtlb_pkg::CMD_LOOKUP:
                        begin
                            ram_re     = 1'b1;
                            cur_next   = q_head;
                            state_next = dmdtlb_pkg::B_LOOKUP;
                        end
                        dmdtlb_pkg::CMD_FILL:
                        begin
                            ram_we         = 1'b1;
                            rsp_valid_next = 1'b1;
                            rsp_res_next   = finish(q_head.pte, q_head.need, q_head.offset);
                        end
                        dmdtlb_pkg::CMD_FLUSH:
                        begin
                            rsp_valid_next = 1'b1;
                            rsp_res_next   = '0;
                            sweep_cnt_next = '0;
                            state_next     = dmdtlb_pkg::B_SWEEP;
                        end
                        default:
                        begin
                            rsp_valid_next      = 1'b1;
                            rsp_res_next        = '0;
                            rsp_res_next.status = q_head.status;
                        end
                    endcase
                end
            end
            dmdtlb_pkg::B_LOOKUP:
            begin
                // Read data holds until the result register has room.
                if (out_free)
                begin
                    rsp_valid_next = 1'b1;
                    if (rd_valid && rd_tag == cur_reg.page[dmdtlb_pkg::PAGE_BITS-1:TLB_INDEX_BITS])
                    begin
                        rsp_res_next = finish(rd_pte, cur_reg.need, cur_reg.offset);
                    end
                    else
                    begin
                        rsp_res_next           = '0;
                        rsp_res_next.status    = dmdtlb_pkg::ST_MISS;
                        rsp_res_next.walk_page = cur_reg.page[dmdtlb_pkg::WALK_PAGE_W-1:0];
                    end
                    state_next = dmdtlb_pkg::B_IDLE;
                end
            end
            dmdtlb_pkg::B_SWEEP:
            begin
                ram_we         = 1'b1;
                ram_addr       = sweep_cnt_reg;
                ram_wdata      = '0;
                sweep_cnt_next = sweep_cnt_reg + TLB_INDEX_BITS'(1);
                if (sweep_cnt_reg == '1)
                begin
                    init_busy_next = 1'b0;
                    state_next     = dmdtlb_pkg::B_IDLE;
                end
            end
            default:
            begin
                state_next = dmdtlb_pkg::B_IDLE;
            end
        endcase
    end

    `DMDTLB_ASSERT_ALWAYS(a_sweep_no_pop, !(state_reg == dmdtlb_pkg::B_SWEEP && q_pop), "command popped during clearing sweep")
    `DMDTLB_ASSERT_ALWAYS(a_ram_one_op, !(ram_we && ram_re), "entry memory read and written in one cycle")
    `DMDTLB_ASSERT_ALWAYS(a_init_in_sweep, !init_busy_reg || state_reg == dmdtlb_pkg::B_SWEEP, "initial clearing left the sweep state early")
    `DMDTLB_ASSERT_NEXT(a_lookup_result, state_reg == dmdtlb_pkg::B_LOOKUP && out_free, rsp_valid_reg, "lookup result not registered")

endmodule

// File: design/direct_mapped_data_tlb_top.sv
// Top level of the direct-mapped data translation buffer.
`timescale 1ns / 1ps
// A request that is taken is first registered in the queue. A lookup then holds the back end
// through the entry memory read and then the tag compare before its result is registered;
// a fill or fault goes from the queue head into the result register, and a flush clears the memory.
// Reset: the address limit returns to 2**47 and the back end clears all 2**TLB_INDEX_BITS
// entries, one a cycle, while request ready stays low.
module direct_mapped_data_tlb_top #(
    parameter int TLB_INDEX_BITS = 10
) (
    input  logic                               clk,
    input  logic                               rst_n,
    dmdtlb_req_if.sink                         req,
    dmdtlb_rsp_if.source                       rsp,
    input  logic                               cfg_wr_en,
    input  logic [dmdtlb_pkg::VA_LIMIT_W-1:0]  cfg_wr_data
);

    // The front end checks the address limit, strips the pointer tag and decides what the
    // back end must do; requests that can be answered without the entry memory (faults,
    // unknown opcodes) travel as ready-made replies so that ordering is preserved.
    dmdtlb_pkg::cmd_t            q_cmd;
    dmdtlb_pkg::cmd_t            q_head;
    logic                        q_push;
    logic                        q_pop;
    logic                        q_full;
    logic                        q_not_empty;
    dmdtlb_pkg::back_status_t    back_status;

    dmdtlb_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .req         (req),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .q_full      (q_full),
        .back_status (back_status),
        .q_push      (q_push),
        .q_cmd       (q_cmd)
    );

    // The queue lets the front end keep taking transactions while the back end is busy
    // with a memory read or a flush sweep.
    dmdtlb_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_cmd  (q_cmd),
        .pop       (q_pop),
        .full      (q_full),
        .not_empty (q_not_empty),
        .head      (q_head)
    );

    // The back end owns the entry memory; each entry holds a valid flag, the page number
    // bits above the index and the cached page table entry. The result register holds a
    // finished response until it is taken; the next command leaves the queue only once the
    // register is empty or being emptied in the same cycle.
    dmdtlb_back #(
        .TLB_INDEX_BITS (TLB_INDEX_BITS)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_not_empty (q_not_empty),
        .q_head      (q_head),
        .q_pop       (q_pop),
        .back_status (back_status),
        .rsp         (rsp)
    );

endmodule
